@@ hdl/cdll_pkg.sv @@
// Shared types and codes for the circular doubly linked list engine.
// Depends on nothing; cdll_alloc and the engine top level import it.
package cdll_pkg;

  // Action codes carried by an input transfer. Code 7 acts like a count.
  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_END   = 3'd1;
  localparam logic [2:0] ACT_INS_AT    = 3'd2;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [2:0] ACT_DEL_END   = 3'd4;
  localparam logic [2:0] ACT_DEL_AT    = 3'd5;
  localparam logic [2:0] ACT_COUNT     = 3'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LOOK,
    S_LINK,
    S_SOLO,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         node_count;
  } out_item_t;

  typedef struct packed {
    logic pop;
    logic push;
  } alloc_cmd_t;

endpackage

@@ hdl/cdll_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Uses no package contents; instantiated for every store of the engine.
module cdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // The read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cdll_alloc.sv @@
// Slot allocator: a high-water fill count plus a stack of released slots.
// Depends on cdll_pkg and cdll_ram.
module cdll_alloc #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cdll_pkg::alloc_cmd_t        cmd_i,
  input  logic [$clog2(CAPACITY)-1:0] push_slot_i,
  output logic [$clog2(CAPACITY)-1:0] slot_o
);
  import cdll_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic [LW-1:0] fill_q, fill_d;
  logic [LW-1:0] sp_q, sp_d;
  logic          from_stack_q, from_stack_d;
  logic [SW-1:0] fill_slot_q, fill_slot_d;
  logic [LW-1:0] sp_dec;
  logic [SW-1:0] stack_rdata;
  logic          stack_re;

  assign sp_dec   = sp_q - LW'(1);
  assign stack_re = cmd_i.pop && (sp_q != '0);

  // Slots below the fill count have been handed out at least once; freed
  // slots are kept on the stack, so no clearing pass is needed after reset.
  always_comb begin
    fill_d       = fill_q;
    sp_d         = sp_q;
    from_stack_d = from_stack_q;
    fill_slot_d  = fill_slot_q;
    if (cmd_i.pop) begin
      if (sp_q == '0) begin
        fill_slot_d  = fill_q[SW-1:0];
        fill_d       = fill_q + LW'(1);
        from_stack_d = 1'b0;
      end else begin
        sp_d         = sp_dec;
        from_stack_d = 1'b1;
      end
    end else if (cmd_i.push) begin
      sp_d = sp_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      sp_q         <= '0;
      from_stack_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      sp_q         <= sp_d;
      from_stack_q <= from_stack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_slot_q <= fill_slot_d;
  end

  cdll_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (sp_q[SW-1:0]),
    .wdata_i (push_slot_i),
    .re_i    (stack_re),
    .raddr_i (sp_dec[SW-1:0]),
    .rdata_o (stack_rdata)
  );

  assign slot_o = from_stack_q ? stack_rdata : fill_slot_q;

endmodule

@@ hdl/circular_doubly_linked_list_engine_unit.sv @@
// Top level of the circular doubly linked list engine: sequencer, link and
// value stores, and the result register. Depends on cdll_pkg, cdll_ram and
// cdll_alloc.
//
// Usage: one input transfer (action, position, value) gives exactly one
// result transfer (status, removed value, node count after the action).
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low at a rising edge. in_stall_o is high while an item is being
// worked on, so the engine takes one item at a time.
// Steps per item, from acceptance to the result being registered:
//   count, rejected actions:    S_RESP
//   delete at position p:       walk to p, S_LOOK, S_RESP
//   insert at position p <= n:  walk to p, S_LOOK, S_LINK, S_RESP
//   insert into an empty list:  S_SOLO, S_RESP
// Delete at end walks back from the head; insert at end does not walk.
// The walk along the links does one read of a link RAM per cycle.
// A finished result waits in the output register while out_stall_i is
// high; the engine then holds its last state until the register frees up.
// Reset empties the list at once; the stores need no clearing pass.
module circular_doubly_linked_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cdll_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cdll_pkg::out_item_t out_item_o
);
  import cdll_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > 8) ? LW : 8) + 1;

  fsm_e state_q, state_d;

  logic [SW-1:0]      head_q, head_d;
  logic [LW-1:0]      len_q, len_d;
  logic [SW-1:0]      steps_q, steps_d;
  logic               back_q, back_d;
  logic [SW-1:0]      cur_q, cur_d;
  logic [SW-1:0]      before_q, before_d;
  logic               is_ins_q, is_ins_d;
  logic               new_head_q, new_head_d;
  logic signed [31:0] val_q, val_d;
  status_e            status_q, status_d;
  logic signed [31:0] removed_q, removed_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  // Decode of the item offered at the input.
  logic [CW-1:0] len_w, pos_w, pos_sel;
  logic          dec_ins, dec_del, dec_go_ins, dec_go_del, dec_go, dec_back;
  status_e       dec_status;
  logic [SW-1:0] dec_steps;

  logic accept, out_free;

  // Memory ports.
  logic          next_we, prev_we, val_we;
  logic [SW-1:0] next_waddr, prev_waddr, val_waddr;
  logic [SW-1:0] next_wdata, prev_wdata;
  logic          next_re, prev_re, val_re;
  logic [SW-1:0] next_raddr, prev_raddr, val_raddr;
  logic [SW-1:0] next_rdata, prev_rdata;
  logic [31:0]   val_rdata;

  alloc_cmd_t    alloc_cmd;
  logic [SW-1:0] new_slot;
  logic [SW-1:0] link_w;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign link_w     = back_q ? prev_rdata : next_rdata;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    len_w      = CW'(len_q);
    pos_w      = CW'(in_item_i.position);
    pos_sel    = CW'(1);
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_status = ST_OK;
    dec_go_ins = 1'b0;
    dec_go_del = 1'b0;
    case (in_item_i.action)
      ACT_INS_FRONT: begin
        dec_ins = 1'b1;
      end
      ACT_INS_END: begin
        dec_ins = 1'b1;
        pos_sel = len_w + CW'(1);
      end
      ACT_INS_AT: begin
        dec_ins = 1'b1;
        pos_sel = pos_w;
      end
      ACT_DEL_FRONT: begin
        dec_del = 1'b1;
      end
      ACT_DEL_END: begin
        dec_del = 1'b1;
        pos_sel = len_w;
      end
      ACT_DEL_AT: begin
        dec_del = 1'b1;
        pos_sel = pos_w;
      end
      default: begin
      end
    endcase

    if (dec_ins) begin
      if ((pos_sel == '0) || (pos_sel > len_w + CW'(1))) begin
        dec_status = ST_INVALID;
      end else if (len_q == LW'(CAPACITY)) begin
        dec_status = ST_FULL;
      end else begin
        dec_go_ins = 1'b1;
      end
    end else if (dec_del) begin
      if (len_q == '0) begin
        dec_status = ST_EMPTY;
      end else if ((pos_sel == '0) || (pos_sel > len_w)) begin
        dec_status = ST_INVALID;
      end else begin
        dec_go_del = 1'b1;
      end
    end
    dec_go = dec_go_ins || dec_go_del;

    // The last node is one step back from the head.
    dec_back = (in_item_i.action == ACT_DEL_END) && (len_q > LW'(1));
    if (dec_back) begin
      dec_steps = SW'(1);
    end else if ((pos_sel <= len_w) && (pos_sel != '0)) begin
      dec_steps = SW'(pos_sel - CW'(1));
    end else begin
      // Appending goes in front of the head.
      dec_steps = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!dec_go) begin
            state_d = S_RESP;
          end else if (dec_go_ins && (len_q == '0)) begin
            state_d = S_SOLO;
          end else if (dec_steps == '0) begin
            state_d = S_LOOK;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (steps_q == SW'(1)) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = is_ins_q ? S_LINK : S_RESP;
      end
      S_LINK: begin
        state_d = S_RESP;
      end
      S_SOLO: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    head_d      = head_q;
    len_d       = len_q;
    steps_d     = steps_q;
    back_d      = back_q;
    cur_d       = cur_q;
    before_d    = before_q;
    is_ins_d    = is_ins_q;
    new_head_d  = new_head_q;
    val_d       = val_q;
    status_d    = status_q;
    removed_d   = removed_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    next_we     = 1'b0;
    prev_we     = 1'b0;
    val_we      = 1'b0;
    next_waddr  = new_slot;
    prev_waddr  = new_slot;
    val_waddr   = new_slot;
    next_wdata  = cur_q;
    prev_wdata  = prev_rdata;
    next_re     = 1'b0;
    prev_re     = 1'b0;
    val_re      = 1'b0;
    next_raddr  = head_q;
    prev_raddr  = head_q;
    val_raddr   = head_q;
    alloc_cmd   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          is_ins_d      = dec_go_ins;
          back_d        = dec_back;
          steps_d       = dec_steps;
          new_head_d    = (pos_sel == CW'(1));
          val_d         = in_item_i.value;
          status_d      = dec_status;
          removed_d     = '0;
          cur_d         = head_q;
          alloc_cmd.pop = dec_go_ins;
          if (dec_go && !(dec_go_ins && (len_q == '0))) begin
            if (dec_steps == '0) begin
              prev_re = 1'b1;
              next_re = 1'b1;
              val_re  = 1'b1;
            end else if (dec_back) begin
              prev_re = 1'b1;
            end else begin
              next_re = 1'b1;
            end
          end
        end
      end
      S_WALK: begin
        steps_d = steps_q - SW'(1);
        cur_d   = link_w;
        if (steps_q == SW'(1)) begin
          prev_re    = 1'b1;
          next_re    = 1'b1;
          val_re     = 1'b1;
          prev_raddr = link_w;
          next_raddr = link_w;
          val_raddr  = link_w;
        end else begin
          next_re    = 1'b1;
          next_raddr = link_w;
        end
      end
      S_LOOK: begin
        if (is_ins_q) begin
          // New node sits between the node before cur and cur itself.
          before_d   = prev_rdata;
          next_we    = 1'b1;
          prev_we    = 1'b1;
          val_we     = 1'b1;
          next_wdata = cur_q;
          prev_wdata = prev_rdata;
          if (new_head_q) begin
            head_d = new_slot;
          end
        end else begin
          removed_d      = val_rdata;
          alloc_cmd.push = 1'b1;
          len_d          = len_q - LW'(1);
          if (len_q == LW'(1)) begin
            head_d = '0;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
            if (cur_q == head_q) begin
              head_d = next_rdata;
            end
          end
        end
      end
      S_LINK: begin
        next_we    = 1'b1;
        next_waddr = before_q;
        next_wdata = new_slot;
        prev_we    = 1'b1;
        prev_waddr = cur_q;
        prev_wdata = new_slot;
        len_d      = len_q + LW'(1);
      end
      S_SOLO: begin
        next_we    = 1'b1;
        next_wdata = new_slot;
        prev_we    = 1'b1;
        prev_wdata = new_slot;
        val_we     = 1'b1;
        head_d     = new_slot;
        len_d      = len_q + LW'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.status        = status_q;
          out_item_d.removed_value = removed_q;
          out_item_d.node_count    = 5'(len_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q    <= steps_d;
    back_q     <= back_d;
    cur_q      <= cur_d;
    before_q   <= before_d;
    is_ins_q   <= is_ins_d;
    new_head_q <= new_head_d;
    val_q      <= val_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    out_item_q <= out_item_d;
  end

  cdll_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_next (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (next_re),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  cdll_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_prev (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (prev_re),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  cdll_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_value (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  cdll_alloc #(
    .CAPACITY (CAPACITY)
  ) u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (alloc_cmd),
    .push_slot_i (cur_q),
    .slot_o      (new_slot)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
